### sv/mlsf_pkg.sv
// ----------------------------------------------------------------------------
// MAC learning switch forwarder package
// Transaction types, action and register codes and sequencer states shared by
// the forwarder and its address table.
// ----------------------------------------------------------------------------
package mlsf_pkg;

    localparam int MAC_W  = 48;
    localparam int PORT_W = 4;
    localparam int MASK_W = 16;
    localparam int CFG_W  = 48;

    localparam logic [1:0] ACT_LOCAL   = 2'd0;
    localparam logic [1:0] ACT_FORWARD = 2'd1;
    localparam logic [1:0] ACT_FLOOD   = 2'd2;

    localparam logic [1:0] CFG_OWN_MAC   = 2'd0;
    localparam logic [1:0] CFG_PORT_CNT  = 2'd1;
    localparam logic [1:0] CFG_CONNECTED = 2'd2;

    localparam logic [4:0] PORT_CNT_RST = 5'd16;

    typedef struct packed {
        logic [MAC_W-1:0]  src_mac;
        logic [MAC_W-1:0]  dst_mac;
        logic [PORT_W-1:0] ingress_port;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        action;
        logic [PORT_W-1:0] egress_port;
        logic [MASK_W-1:0] flood_mask;
        logic              learned;
        logic              table_full;
    } t_out_item;

    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DECIDE
    } t_state;

endpackage

### sv/mac_learning_switch_forwarder.sv
// ----------------------------------------------------------------------------
// MAC learning switch forwarder
// Makes one forwarding decision per frame header, learning source addresses
// into a fixed table that is walked entry by entry.
// ----------------------------------------------------------------------------
// Usage:
// Frame headers arrive on the input channel (i_in_valid, o_in_stall, i_in_data)
// and one decision per header leaves on the output channel (o_out_valid,
// i_out_stall, o_out_data). A transaction moves at an edge with valid high and
// stall low. Configuration writes use i_cfg_valid/o_cfg_ready, with the
// register index on i_cfg_index and the value on i_cfg_data; o_cfg_ready is
// always high. The user makes writes only while the block is idle; the block
// itself does not enforce this. A header is matched against the learned
// entries (at most TABLE_DEPTH): the table is read one entry per cycle through
// its single read port, each entry read is compared in the cycle after, the
// walk ends once no read or compare is pending, and the decision is registered
// in ST_DECIDE once the output is free. With an empty table the walk ends at
// once, and frames for the own address skip the walk. o_in_stall stays high
// until the result is registered, so the next header is accepted in the cycle
// after that at the earliest. A finished result waits in the output register;
// if the receiver still stalls the previous result, the next decision holds.
// Reset empties the table at once through its entry count and sets the
// registers to own address 0, sixteen ports in use and no ports connected.
// ----------------------------------------------------------------------------
module mac_learning_switch_forwarder #(
    parameter int TABLE_DEPTH = 64,
    parameter int PORT_MAX    = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  mlsf_pkg::t_in_item         i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output mlsf_pkg::t_out_item        o_out_data,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [mlsf_pkg::CFG_W-1:0] i_cfg_data
);
    import mlsf_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state            r_state, n_state;
    t_in_item          r_item, n_item;
    logic              r_local, n_local;
    logic              r_same, n_same;
    logic [CW-1:0]     r_rd_idx, n_rd_idx;
    logic              r_cmp_vld, n_cmp_vld;
    logic              r_src_hit, n_src_hit;
    logic              r_dst_hit, n_dst_hit;
    logic [PORT_W-1:0] r_dst_port, n_dst_port;
    logic [CW-1:0]     r_entry_count, n_entry_count;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out_data, n_out_data;
    logic [MAC_W-1:0]  r_own_mac, n_own_mac;
    logic [4:0]        r_port_count, n_port_count;
    logic [MASK_W-1:0] r_connected, n_connected;

    logic              rd_en;
    logic              wr_en;
    t_entry            wr_entry;
    t_entry            rd_entry;
    logic              room;
    logic              learn;
    logic [MASK_W-1:0] in_use;
    logic [MASK_W-1:0] flood;

    mlsf_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk      (i_clk),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_entry_count[AW-1:0]),
        .i_wr_entry (wr_entry),
        .i_rd_en    (rd_en),
        .i_rd_addr  (r_rd_idx[AW-1:0]),
        .o_rd_entry (rd_entry)
    );

    always_comb begin
        for (int b = 0; b < MASK_W; b++) begin
            in_use[b] = (b < int'(r_port_count)) && (b < PORT_MAX);
        end
    end

    assign flood    = r_connected & in_use & ~(MASK_W'(1) << r_item.ingress_port);
    assign room     = r_entry_count < CW'(TABLE_DEPTH);
    assign learn    = !r_local && !r_src_hit && room;
    assign wr_entry = '{mac: r_item.src_mac, port: r_item.ingress_port};

    always_comb begin
        n_state       = r_state;
        n_item        = r_item;
        n_local       = r_local;
        n_same        = r_same;
        n_rd_idx      = r_rd_idx;
        n_cmp_vld     = r_cmp_vld;
        n_src_hit     = r_src_hit;
        n_dst_hit     = r_dst_hit;
        n_dst_port    = r_dst_port;
        n_entry_count = r_entry_count;
        n_out_valid   = r_out_valid;
        n_out_data    = r_out_data;
        n_own_mac     = r_own_mac;
        n_port_count  = r_port_count;
        n_connected   = r_connected;
        rd_en         = 1'b0;
        wr_en         = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item     = i_in_data;
                    n_local    = i_in_data.dst_mac == r_own_mac;
                    n_same     = i_in_data.dst_mac == i_in_data.src_mac;
                    n_rd_idx   = '0;
                    n_cmp_vld  = 1'b0;
                    n_src_hit  = 1'b0;
                    n_dst_hit  = 1'b0;
                    n_dst_port = '0;
                    n_state    = (i_in_data.dst_mac == r_own_mac) ? ST_DECIDE : ST_WALK;
                end
            end
            ST_WALK: begin
                rd_en     = r_rd_idx < r_entry_count;
                n_cmp_vld = rd_en;
                if (rd_en) begin
                    n_rd_idx = r_rd_idx + CW'(1);
                end
                if (r_cmp_vld) begin
                    if (rd_entry.mac == r_item.src_mac) begin
                        n_src_hit = 1'b1;
                    end
                    if (rd_entry.mac == r_item.dst_mac && !r_dst_hit) begin
                        n_dst_hit  = 1'b1;
                        n_dst_port = rd_entry.port;
                    end
                end
                if (!rd_en && !r_cmp_vld) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    if (!r_local) begin
                        n_out_data.learned    = learn;
                        n_out_data.table_full = !r_src_hit && !room;
                        if (r_dst_hit) begin
                            n_out_data.action      = ACT_FORWARD;
                            n_out_data.egress_port = r_dst_port;
                        end else if (learn && r_same) begin
                            n_out_data.action      = ACT_FORWARD;
                            n_out_data.egress_port = r_item.ingress_port;
                        end else begin
                            n_out_data.action     = ACT_FLOOD;
                            n_out_data.flood_mask = flood;
                        end
                    end else begin
                        n_out_data.action = ACT_LOCAL;
                    end
                    wr_en = learn;
                    if (learn) begin
                        n_entry_count = r_entry_count + CW'(1);
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OWN_MAC:   n_own_mac    = i_cfg_data[MAC_W-1:0];
                CFG_PORT_CNT:  n_port_count = i_cfg_data[4:0];
                CFG_CONNECTED: n_connected  = i_cfg_data[MASK_W-1:0];
                default:       n_own_mac    = r_own_mac;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_rd_idx      <= '0;
            r_cmp_vld     <= 1'b0;
            r_entry_count <= '0;
            r_out_valid   <= 1'b0;
            r_own_mac     <= '0;
            r_port_count  <= PORT_CNT_RST;
            r_connected   <= '0;
        end else begin
            r_state       <= n_state;
            r_rd_idx      <= n_rd_idx;
            r_cmp_vld     <= n_cmp_vld;
            r_entry_count <= n_entry_count;
            r_out_valid   <= n_out_valid;
            r_own_mac     <= n_own_mac;
            r_port_count  <= n_port_count;
            r_connected   <= n_connected;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_local    <= n_local;
        r_same     <= n_same;
        r_src_hit  <= n_src_hit;
        r_dst_hit  <= n_dst_hit;
        r_dst_port <= n_dst_port;
        r_out_data <= n_out_data;
    end

    assign o_in_stall  = r_state != ST_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entry_count <= CW'(TABLE_DEPTH))
        else $error("Entry count exceeds the table depth.");

    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.table_full) |-> (r_entry_count == CW'(TABLE_DEPTH)))
        else $error("Table full reported while the table has room.");

    a_learn_excl_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.learned && o_out_data.table_full))
        else $error("Learned and table full reported together.");

    a_learn_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && r_state == ST_DECIDE) |=> (r_entry_count == $past(r_entry_count) + CW'(1)))
        else $error("Learning did not advance the entry count.");
`endif

endmodule

### sv/mlsf_table.sv
// ----------------------------------------------------------------------------
// MAC learning switch address table
// Single write port, single registered read port memory of learned entries.
// ----------------------------------------------------------------------------
module mlsf_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  mlsf_pkg::t_entry i_wr_entry,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    output mlsf_pkg::t_entry o_rd_entry
);
    import mlsf_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_entry <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_entry = r_rd_entry;

endmodule
